>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is low
`define VFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked around reset
`define VFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/vfc_pkg.sv
// ---------------------------------------------------------------------------
// vfc_pkg
// types, codes and helpers for the six-plane sphere cull block
// ---------------------------------------------------------------------------
package vfc_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // item operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // writing this entry rebuilds the planes
    localparam logic [3:0] LAST_ENTRY = 4'd15;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CORNER_ACC,
        S_CORNER_DIV,
        S_CORNER_WAIT,
        S_PLANE_LOAD,
        S_PLANE_DIFF,
        S_CROSS_MUL,
        S_CROSS_ACC,
        S_MAG,
        S_SHIFT,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT,
        S_NORM_DIV,
        S_NORM_WAIT,
        S_DOT_MUL,
        S_DOT_ACC,
        S_PLANE_WRITE,
        S_TEST_MUL,
        S_TEST_ACC,
        S_TEST_CMP,
        S_OUT
    } t_state;

    // corner triple of each plane: left, right, top, bottom, near, far
    function automatic logic [2:0] tri_corner(input logic [2:0] pl, input logic [1:0] sel);
        logic [8:0] row;
        begin
            case (pl)
                3'd0:    row = {3'd4, 3'd0, 3'd2};
                3'd1:    row = {3'd1, 3'd5, 3'd7};
                3'd2:    row = {3'd4, 3'd5, 3'd1};
                3'd3:    row = {3'd2, 3'd3, 3'd7};
                3'd4:    row = {3'd0, 3'd1, 3'd3};
                default: row = {3'd5, 3'd4, 3'd6};
            endcase
            case (sel)
                2'd0:    return row[8:6];
                2'd1:    return row[5:3];
                default: return row[2:0];
            endcase
        end
    endfunction

    // clamp a 35-bit sum to 32 bits
    function automatic logic signed [31:0] sat32_35(input logic signed [34:0] v);
        begin
            if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
                return v[31:0];
            end
            return v[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
    endfunction

    // saturating 32-bit difference
    function automatic logic signed [31:0] sat_sub32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] d;
        begin
            d = {a[31], a} - {b[31], b};
            if (d[32] != d[31]) begin
                return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
            return d[31:0];
        end
    endfunction

    // clamp a 66-bit value to 48 bits
    function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
        begin
            if (v[65:47] == '0 || v[65:47] == '1) begin
                return v[47:0];
            end
            return v[65] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
    endfunction

endpackage

>>> hw/rtl/vfc_div.sv
// ---------------------------------------------------------------------------
// vfc_div
// unsigned restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module vfc_div #(
    parameter int DW = 32 + vfc_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [31:0]   i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [31:0]     r_rem;
    logic [DW-1:0]   r_quo;
    logic [31:0]     r_dvs;

    logic [32:0]     w_rem_sh;
    logic            w_bit;
    logic [31:0]     w_rem;

    // one trial subtract a cycle
    assign w_rem_sh = {r_rem, r_quo[DW-1]};
    assign w_bit    = (w_rem_sh >= {1'b0, r_dvs});
    assign w_rem    = w_bit ? 32'(w_rem_sh - {1'b0, r_dvs}) : w_rem_sh[31:0];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_rem;
            r_quo <= {r_quo[DW-2:0], w_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

>>> hw/rtl/view_frustum_sphere_cull.sv
// ---------------------------------------------------------------------------
// view_frustum_sphere_cull
// six-plane frustum test of spheres, planes rebuilt from the inverse
// view-projection matrix with one shared multiplier, divider and root step
// ---------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | i_in_valid / o_in_ready | operation, entry_index, entry_value,
//          |                         | center_x/y/z, radius
//  out     | o_out_valid/i_out_ready | inside_res
//
//  load item: returns to idle at once. test item: six planes, three products each
//  on the shared multiplier plus one compare each, before the next item.
//  load of entry 15: plane rebuild, mostly spent in the bit-serial divider
//  (at most 42 divides; a zero w or a zero length skips its divide).
//  after reset the block runs the same rebuild on the identity matrix first.
//  a pending result in the output register stalls a finished test and the next item.
// ---------------------------------------------------------------------------
module view_frustum_sphere_cull #(
    parameter int FRAC_BITS = vfc_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [3:0]         i_entry_index,
    input  logic signed [31:0] i_entry_value,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic signed [31:0] i_center_z,
    input  logic [30:0]        i_radius,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_inside_res
);

    localparam int DW = 32 + FRAC_BITS;
    localparam int NW = FRAC_BITS + 2;

    vfc_pkg::t_state r_state, n_state;

    logic signed [31:0]   r_mat [16];
    logic signed [31:0]   r_t [4];
    logic signed [31:0]   r_pts [8][3];
    logic signed [31:0]   r_p0 [3];
    logic signed [31:0]   r_p1 [3];
    logic signed [31:0]   r_p2 [3];
    logic signed [31:0]   r_a [3];
    logic signed [31:0]   r_b [3];
    logic signed [65:0]   r_c [3];
    logic [63:0]          r_m [3];
    logic [2:0]           r_cneg;
    logic [63:0]          r_sum;
    logic [63:0]          r_s;
    logic [63:0]          r_res;
    logic [63:0]          r_bit;
    logic signed [NW-1:0] r_n [3];
    logic signed [65:0]   r_dot;
    logic signed [65:0]   r_prod;
    logic signed [NW-1:0] r_pn [6][3];
    logic signed [47:0]   r_pd [6];
    logic signed [31:0]   r_cx, r_cy, r_cz;
    logic [30:0]          r_rad;
    logic                 r_inside;
    logic                 r_out_valid;
    logic                 r_out_inside;
    logic signed [34:0]   r_acc;
    logic [2:0]           r_ci;
    logic [1:0]           r_j;
    logic [1:0]           r_r;
    logic [2:0]           r_pi;
    logic [1:0]           r_k;
    logic [2:0]           r_step;
    logic [1:0]           r_ld;
    logic [4:0]           r_cnt;

    logic                 w_accept;
    logic                 w_div_start;
    logic [DW-1:0]        w_div_dividend;
    logic [31:0]          w_div_divisor;
    logic                 w_div_done;
    logic [DW-1:0]        w_div_quot;
    logic signed [32:0]   w_ma, w_mb;
    logic signed [31:0]   w_e;
    logic signed [34:0]   w_term;
    logic signed [34:0]   w_acc_sum;
    logic signed [31:0]   w_tj;
    logic [31:0]          w_tj_mag;
    logic [31:0]          w_t3_mag;
    logic                 w_t3_zero;
    logic                 w_qneg;
    logic                 w_big_pos;
    logic                 w_big_neg;
    logic signed [31:0]   w_corner_q;
    logic signed [31:0]   w_corner_w0;
    logic                 w_big;
    logic                 w_len_zero;
    logic [63:0]          w_sum;
    logic [63:0]          w_trial;
    logic signed [NW-1:0] w_qn;
    logic                 w_round;
    logic signed [65:0]   w_tq;
    logic signed [47:0]   w_plane_d;
    logic signed [66:0]   w_dist;
    logic signed [31:0]   w_csel;
    logic [1:0]           w_k_next;
    logic                 w_out_load;

    assign o_in_ready = (r_state == vfc_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_k_next   = (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;

    // corner row term: x sign from bit 0, y sign from bit 1, z present on bit 2
    assign w_e = r_mat[{r_r, r_j}];
    always_comb begin
        case (r_r)
            2'd0:    w_term = r_ci[0] ? 35'(w_e) : -35'(w_e);
            2'd1:    w_term = r_ci[1] ? -35'(w_e) : 35'(w_e);
            2'd2:    w_term = r_ci[2] ? 35'(w_e) : 35'sd0;
            default: w_term = 35'(w_e);
        endcase
    end
    assign w_acc_sum = ((r_r == 2'd0) ? 35'sd0 : r_acc) + w_term;

    // perspective divide of one corner coordinate
    assign w_tj       = r_t[r_j];
    assign w_tj_mag   = w_tj[31] ? 32'(-w_tj) : 32'(w_tj);
    assign w_t3_mag   = r_t[3][31] ? 32'(-r_t[3]) : 32'(r_t[3]);
    assign w_t3_zero  = (r_t[3] == 32'sd0);
    assign w_qneg     = w_tj[31] ^ r_t[3][31];
    assign w_big_pos  = |w_div_quot[DW-1:31];
    assign w_big_neg  = (|w_div_quot[DW-1:32]) || (w_div_quot[31] && (|w_div_quot[30:0]));
    assign w_corner_q = w_qneg ?
                        (w_big_neg ? 32'sh8000_0000 : -$signed(w_div_quot[31:0])) :
                        (w_big_pos ? 32'sh7FFF_FFFF : $signed(w_div_quot[31:0]));
    // zero w: coordinate goes to the extreme of its sign, a zero stays zero
    assign w_corner_w0 = (w_tj == 32'sd0) ? 32'sd0 :
                         (w_tj[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    // normalization helpers
    assign w_big      = (|r_m[0][63:31]) || (|r_m[1][63:31]) || (|r_m[2][63:31]);
    assign w_len_zero = (r_res[31:0] == 32'd0);
    assign w_sum      = r_sum + r_prod[63:0];
    assign w_trial    = r_res + r_bit;
    assign w_qn       = $signed(w_div_quot[NW-1:0]);

    // dot product scaled back, truncating toward zero
    assign w_round   = r_dot[65] && (|r_dot[FRAC_BITS-1:0]);
    assign w_tq      = (r_dot >>> FRAC_BITS) + $signed({65'd0, w_round});
    assign w_plane_d = vfc_pkg::sat48(-w_tq);
    assign w_dist    = {w_tq[65], w_tq} + {{19{r_pd[r_pi][47]}}, r_pd[r_pi]};

    always_comb begin
        case (r_k)
            2'd0:    w_csel = r_cx;
            2'd1:    w_csel = r_cy;
            default: w_csel = r_cz;
        endcase
    end

    // next state, divider and multiplier operand selection
    always_comb begin
        n_state        = r_state;
        w_div_start    = 1'b0;
        w_div_dividend = {w_tj_mag, {FRAC_BITS{1'b0}}};
        w_div_divisor  = w_t3_mag;
        w_ma           = 33'sd0;
        w_mb           = 33'sd0;
        case (r_state)
            vfc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_operation == vfc_pkg::OP_TEST) begin
                        n_state = vfc_pkg::S_TEST_MUL;
                    end else if (i_entry_index == vfc_pkg::LAST_ENTRY) begin
                        n_state = vfc_pkg::S_CORNER_ACC;
                    end
                end
            end
            vfc_pkg::S_CORNER_ACC: begin
                if (r_r == 2'd3 && r_j == 2'd3) begin
                    n_state = vfc_pkg::S_CORNER_DIV;
                end
            end
            vfc_pkg::S_CORNER_DIV, vfc_pkg::S_CORNER_WAIT: begin
                if (r_state == vfc_pkg::S_CORNER_DIV && !w_t3_zero) begin
                    w_div_start = 1'b1;
                    n_state     = vfc_pkg::S_CORNER_WAIT;
                end else if (r_state == vfc_pkg::S_CORNER_DIV || w_div_done) begin
                    if (r_j != 2'd2) begin
                        n_state = vfc_pkg::S_CORNER_DIV;
                    end else if (r_ci == 3'd7) begin
                        n_state = vfc_pkg::S_PLANE_LOAD;
                    end else begin
                        n_state = vfc_pkg::S_CORNER_ACC;
                    end
                end
            end
            vfc_pkg::S_PLANE_LOAD: begin
                if (r_ld == 2'd2) begin
                    n_state = vfc_pkg::S_PLANE_DIFF;
                end
            end
            vfc_pkg::S_PLANE_DIFF: n_state = vfc_pkg::S_CROSS_MUL;
            vfc_pkg::S_CROSS_MUL: begin
                case (r_step)
                    3'd0:    begin w_ma = 33'(r_a[1]); w_mb = 33'(r_b[2]); end
                    3'd1:    begin w_ma = 33'(r_a[2]); w_mb = 33'(r_b[1]); end
                    3'd2:    begin w_ma = 33'(r_a[2]); w_mb = 33'(r_b[0]); end
                    3'd3:    begin w_ma = 33'(r_a[0]); w_mb = 33'(r_b[2]); end
                    3'd4:    begin w_ma = 33'(r_a[0]); w_mb = 33'(r_b[1]); end
                    default: begin w_ma = 33'(r_a[1]); w_mb = 33'(r_b[0]); end
                endcase
                n_state = vfc_pkg::S_CROSS_ACC;
            end
            vfc_pkg::S_CROSS_ACC: begin
                n_state = (r_step == 3'd5) ? vfc_pkg::S_MAG : vfc_pkg::S_CROSS_MUL;
            end
            vfc_pkg::S_MAG: n_state = vfc_pkg::S_SHIFT;
            vfc_pkg::S_SHIFT: begin
                if (!w_big) begin
                    n_state = vfc_pkg::S_SQ_MUL;
                end
            end
            vfc_pkg::S_SQ_MUL: begin
                w_ma    = $signed({2'b00, r_m[r_k][30:0]});
                w_mb    = $signed({2'b00, r_m[r_k][30:0]});
                n_state = vfc_pkg::S_SQ_ACC;
            end
            vfc_pkg::S_SQ_ACC: begin
                n_state = (r_k == 2'd2) ? vfc_pkg::S_SQRT : vfc_pkg::S_SQ_MUL;
            end
            vfc_pkg::S_SQRT: begin
                if (r_cnt == 5'd31) begin
                    n_state = vfc_pkg::S_NORM_DIV;
                end
            end
            vfc_pkg::S_NORM_DIV, vfc_pkg::S_NORM_WAIT: begin
                w_div_dividend = {1'b0, r_m[r_k][30:0], {FRAC_BITS{1'b0}}};
                w_div_divisor  = r_res[31:0];
                if (r_state == vfc_pkg::S_NORM_DIV && !w_len_zero) begin
                    w_div_start = 1'b1;
                    n_state     = vfc_pkg::S_NORM_WAIT;
                end else if (r_state == vfc_pkg::S_NORM_DIV || w_div_done) begin
                    n_state = (r_k == 2'd2) ? vfc_pkg::S_DOT_MUL : vfc_pkg::S_NORM_DIV;
                end
            end
            vfc_pkg::S_DOT_MUL: begin
                w_ma    = {{(33-NW){r_n[r_k][NW-1]}}, r_n[r_k]};
                w_mb    = 33'(r_p0[r_k]);
                n_state = vfc_pkg::S_DOT_ACC;
            end
            vfc_pkg::S_DOT_ACC: begin
                n_state = (r_k == 2'd2) ? vfc_pkg::S_PLANE_WRITE : vfc_pkg::S_DOT_MUL;
            end
            vfc_pkg::S_PLANE_WRITE: begin
                n_state = (r_pi == 3'd5) ? vfc_pkg::S_IDLE : vfc_pkg::S_PLANE_LOAD;
            end
            vfc_pkg::S_TEST_MUL: begin
                w_ma    = {{(33-NW){r_pn[r_pi][r_k][NW-1]}}, r_pn[r_pi][r_k]};
                w_mb    = 33'(w_csel);
                n_state = vfc_pkg::S_TEST_ACC;
            end
            vfc_pkg::S_TEST_ACC: begin
                n_state = (r_k == 2'd2) ? vfc_pkg::S_TEST_CMP : vfc_pkg::S_TEST_MUL;
            end
            vfc_pkg::S_TEST_CMP: begin
                n_state = (r_pi == 3'd5) ? vfc_pkg::S_OUT : vfc_pkg::S_TEST_MUL;
            end
            vfc_pkg::S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = vfc_pkg::S_IDLE;
                end
            end
            default: n_state = vfc_pkg::S_IDLE;
        endcase
    end

    assign w_out_load = (r_state == vfc_pkg::S_OUT) && (!r_out_valid || i_out_ready);

    // state register, reset starts a rebuild from the identity matrix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vfc_pkg::S_CORNER_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    // matrix entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ?
                            (32'sd1 <<< FRAC_BITS) : 32'sd0;
            end
        end else if (w_accept && i_operation == vfc_pkg::OP_LOAD) begin
            r_mat[i_entry_index] <= i_entry_value;
        end
    end

    // shared multiplier, product registered
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_inside <= r_inside;
        end
    end

    // datapath sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci <= '0;
            r_j  <= '0;
            r_r  <= '0;
        end else begin
            case (r_state)
                vfc_pkg::S_IDLE: begin
                    if (i_in_valid) begin
                        r_ci     <= '0;
                        r_j      <= '0;
                        r_r      <= '0;
                        r_pi     <= '0;
                        r_k      <= '0;
                        r_dot    <= '0;
                        r_inside <= 1'b1;
                        r_cx     <= i_center_x;
                        r_cy     <= i_center_y;
                        r_cz     <= i_center_z;
                        r_rad    <= i_radius;
                    end
                end
                vfc_pkg::S_CORNER_ACC: begin
                    r_acc <= w_acc_sum;
                    r_r   <= r_r + 2'd1;
                    if (r_r == 2'd3) begin
                        r_t[r_j] <= vfc_pkg::sat32_35(w_acc_sum);
                        r_j      <= r_j + 2'd1;
                    end
                end
                vfc_pkg::S_CORNER_DIV, vfc_pkg::S_CORNER_WAIT: begin
                    if ((r_state == vfc_pkg::S_CORNER_DIV && w_t3_zero) ||
                        (r_state == vfc_pkg::S_CORNER_WAIT && w_div_done)) begin
                        r_pts[r_ci][r_j] <= w_t3_zero ? w_corner_w0 : w_corner_q;
                        r_r <= '0;
                        if (r_j == 2'd2) begin
                            r_j  <= '0;
                            r_ci <= r_ci + 3'd1;
                            r_pi <= '0;
                            r_ld <= '0;
                        end else begin
                            r_j <= r_j + 2'd1;
                        end
                    end
                end
                vfc_pkg::S_PLANE_LOAD: begin
                    for (int k = 0; k < 3; k++) begin
                        case (r_ld)
                            2'd0:    r_p0[k] <= r_pts[vfc_pkg::tri_corner(r_pi, r_ld)][k];
                            2'd1:    r_p1[k] <= r_pts[vfc_pkg::tri_corner(r_pi, r_ld)][k];
                            default: r_p2[k] <= r_pts[vfc_pkg::tri_corner(r_pi, r_ld)][k];
                        endcase
                    end
                    r_ld <= (r_ld == 2'd2) ? 2'd0 : r_ld + 2'd1;
                end
                vfc_pkg::S_PLANE_DIFF: begin
                    for (int k = 0; k < 3; k++) begin
                        r_a[k] <= vfc_pkg::sat_sub32(r_p0[k], r_p1[k]);
                        r_b[k] <= vfc_pkg::sat_sub32(r_p0[k], r_p2[k]);
                    end
                    r_step <= '0;
                end
                vfc_pkg::S_CROSS_ACC: begin
                    r_c[r_step[2:1]] <= r_step[0] ? (r_c[r_step[2:1]] - r_prod) : r_prod;
                    r_step           <= r_step + 3'd1;
                end
                vfc_pkg::S_MAG: begin
                    for (int k = 0; k < 3; k++) begin
                        r_m[k]    <= r_c[k][65] ? 64'(-r_c[k]) : 64'(r_c[k]);
                        r_cneg[k] <= r_c[k][65];
                    end
                    r_k   <= '0;
                    r_sum <= '0;
                end
                vfc_pkg::S_SHIFT: begin
                    if (w_big) begin
                        for (int k = 0; k < 3; k++) begin
                            r_m[k] <= r_m[k] >> 1;
                        end
                    end
                end
                vfc_pkg::S_SQ_ACC: begin
                    r_sum <= w_sum;
                    r_k   <= w_k_next;
                    r_s   <= w_sum;
                    r_res <= '0;
                    r_bit <= 64'h4000_0000_0000_0000;
                    r_cnt <= '0;
                end
                vfc_pkg::S_SQRT: begin
                    // one root bit per cycle
                    if (r_s >= w_trial) begin
                        r_s   <= r_s - w_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    r_k   <= '0;
                    r_dot <= '0;
                end
                vfc_pkg::S_NORM_DIV: begin
                    // degenerate plane gives a zero normal
                    if (w_len_zero) begin
                        r_n[r_k] <= '0;
                        r_k      <= w_k_next;
                    end
                end
                vfc_pkg::S_NORM_WAIT: begin
                    if (w_div_done) begin
                        r_n[r_k] <= r_cneg[r_k] ? -w_qn : w_qn;
                        r_k      <= w_k_next;
                    end
                end
                vfc_pkg::S_DOT_ACC: begin
                    r_dot <= r_dot + r_prod;
                    r_k   <= w_k_next;
                end
                vfc_pkg::S_PLANE_WRITE: begin
                    for (int k = 0; k < 3; k++) begin
                        r_pn[r_pi][k] <= r_n[k];
                    end
                    r_pd[r_pi] <= w_plane_d;
                    r_pi       <= r_pi + 3'd1;
                    r_ld       <= '0;
                end
                vfc_pkg::S_TEST_ACC: begin
                    r_dot <= r_dot + r_prod;
                    r_k   <= w_k_next;
                end
                vfc_pkg::S_TEST_CMP: begin
                    if (w_dist > $signed({36'd0, r_rad})) begin
                        r_inside <= 1'b0;
                    end
                    r_pi  <= r_pi + 3'd1;
                    r_dot <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    vfc_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    assign o_out_valid  = r_out_valid;
    assign o_inside_res = r_out_inside;

endmodule

>>> hw/rtl/vfc_chk.sv
// ---------------------------------------------------------------------------
// vfc_chk
// port-level checks for the sphere cull block, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vfc_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_operation,
    input logic [3:0] i_entry_index,
    input logic       o_out_valid,
    input logic       i_out_ready
);

    logic w_in_acc;
    logic w_test_acc;
    logic w_last_acc;
    logic w_out_stall;

    // accepted item kinds
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_test_acc  = w_in_acc && (i_operation == vfc_pkg::OP_TEST);
    assign w_last_acc  = w_in_acc && (i_operation == vfc_pkg::OP_LOAD) &&
                         (i_entry_index == vfc_pkg::LAST_ENTRY);
    assign w_out_stall = o_out_valid && !i_out_ready;

    // a waiting result stays offered
    `VFC_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_stall |=> o_out_valid, "out item dropped")

    // a test item keeps the block busy
    `VFC_ASSERT(a_test_busy, i_clk, i_rst_n, w_test_acc |=> !o_in_ready, "ready after test item")

    // the last matrix entry starts a rebuild
    `VFC_ASSERT(a_rebuild_busy, i_clk, i_rst_n, w_last_acc |=> !o_in_ready, "ready after rebuild")

    // reset rebuilds planes and empties the output
    `VFC_ASSERT_ALWAYS(a_rst_busy, i_clk, !i_rst_n |=> !o_in_ready && !o_out_valid, "reset not busy")

endmodule

bind view_frustum_sphere_cull vfc_chk u_vfc_chk (.*);

>>> tb/sv/tb_view_frustum_sphere_cull.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_view_frustum_sphere_cull
// loads inverse view-projection matrices and tests spheres against the
// rebuilt planes; a local plane builder predicts each inside flag
// ---------------------------------------------------------------------------
module tb_view_frustum_sphere_cull;

    localparam int FB         = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 4000;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_operation;
    logic [3:0]         i_entry_index;
    logic signed [31:0] i_entry_value;
    logic signed [31:0] i_center_x;
    logic signed [31:0] i_center_y;
    logic signed [31:0] i_center_z;
    logic [30:0]        i_radius;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_inside_res;

    view_frustum_sphere_cull #(.FRAC_BITS(FB)) u_top (.*);

    // predictor state
    longint mat_entry[16];
    longint plane_coef[24];
    bit     inside_q[$];

    int     n_items, n_tests, n_loads, n_rebuilds, n_inside, n_errors, n_checked;
    int     idle_cycles;
    bit     hold_off, burst_mode;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint sat_to(input longint v, input int bits);
        longint hi;
        hi = (longint'(1) << (bits - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function automatic longint floor_root(input longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // rebuild the six planes from the current matrix
    task automatic build_planes();
        longint pts[8][3];
        longint t[4], a[3], b[3], c[3], n[3], dotp, len;
        longint unsigned m[3], mx;
        int     trip[6][3];
        int     sx, sy, sz;
        trip = '{'{4, 0, 2}, '{1, 5, 7}, '{4, 5, 1}, '{2, 3, 7}, '{0, 1, 3}, '{5, 4, 6}};
        for (int i = 0; i < 8; i++) begin
            sx = i[0] ? 1 : -1;
            sy = i[1] ? -1 : 1;
            sz = i[2] ? 1 : 0;
            for (int j = 0; j < 4; j++)
                t[j] = sat_to(sx * mat_entry[j] + sy * mat_entry[4 + j]
                              + sz * mat_entry[8 + j] + mat_entry[12 + j], 32);
            for (int j = 0; j < 3; j++) begin
                if (t[3] == 0)
                    pts[i][j] = t[j] > 0 ? 64'sd2147483647 :
                                (t[j] < 0 ? -64'sd2147483648 : 0);
                else
                    pts[i][j] = sat_to((t[j] * (longint'(1) << FB)) / t[3], 32);
            end
        end
        for (int p = 0; p < 6; p++) begin
            for (int k = 0; k < 3; k++) begin
                a[k] = sat_to(pts[trip[p][0]][k] - pts[trip[p][1]][k], 32);
                b[k] = sat_to(pts[trip[p][0]][k] - pts[trip[p][2]][k], 32);
            end
            c[0] = a[1] * b[2] - a[2] * b[1];
            c[1] = a[2] * b[0] - a[0] * b[2];
            c[2] = a[0] * b[1] - a[1] * b[0];
            for (int k = 0; k < 3; k++) m[k] = c[k] < 0 ? -c[k] : c[k];
            mx = m[0] > m[1] ? m[0] : m[1];
            if (m[2] > mx) mx = m[2];
            while (mx >= (64'd1 << 31)) begin
                mx >>= 1;
                for (int k = 0; k < 3; k++) m[k] >>= 1;
            end
            len = floor_root(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
            for (int k = 0; k < 3; k++) begin
                n[k] = len == 0 ? 0 : longint'((m[k] << FB) / longint'(len));
                if (c[k] < 0) n[k] = -n[k];
            end
            dotp = n[0] * pts[trip[p][0]][0] + n[1] * pts[trip[p][0]][1]
                 + n[2] * pts[trip[p][0]][2];
            for (int k = 0; k < 3; k++) plane_coef[p * 4 + k] = n[k];
            plane_coef[p * 4 + 3] = sat_to(-(dotp / (longint'(1) << FB)), 48);
        end
    endtask

    // predict one accepted item
    task automatic predict_item(input logic op, input logic [3:0] idx,
                                input logic signed [31:0] val,
                                input logic signed [31:0] cx, input logic signed [31:0] cy,
                                input logic signed [31:0] cz, input logic [30:0] rad);
        longint dotp, dist_v;
        bit     in_flag;
        if (op == vfc_pkg::OP_LOAD) begin
            mat_entry[idx] = val;
            n_loads++;
            if (idx == vfc_pkg::LAST_ENTRY) begin
                build_planes();
                n_rebuilds++;
            end
        end else begin
            in_flag = 1'b1;
            for (int p = 0; p < 6; p++) begin
                dotp = plane_coef[p * 4] * cx + plane_coef[p * 4 + 1] * cy
                     + plane_coef[p * 4 + 2] * cz;
                dist_v = dotp / (longint'(1) << FB) + plane_coef[p * 4 + 3];
                if (dist_v > longint'(rad)) in_flag = 1'b0;
            end
            inside_q.push_back(in_flag);
            n_tests++;
            n_inside += in_flag;
        end
    endtask

    // send one item, with gaps between bursts
    task automatic send_item(input logic op, input logic [3:0] idx,
                             input logic signed [31:0] val,
                             input logic signed [31:0] cx, input logic signed [31:0] cy,
                             input logic signed [31:0] cz, input logic [30:0] rad);
        if (!burst_mode && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        if ($urandom_range(0, 15) == 0) burst_mode = ~burst_mode;
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_entry_index <= idx;
        i_entry_value <= val;
        i_center_x    <= cx;
        i_center_y    <= cy;
        i_center_z    <= cz;
        i_radius      <= rad;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_item(op, idx, val, cx, cy, cz, rad);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_matrix(input logic signed [31:0] m[16]);
        for (int i = 0; i < 16; i++)
            send_item(vfc_pkg::OP_LOAD, i[3:0], m[i], '0, '0, '0, '0);
    endtask

    task automatic test_sphere(input logic signed [31:0] cx, input logic signed [31:0] cy,
                               input logic signed [31:0] cz, input logic [30:0] rad);
        send_item(vfc_pkg::OP_TEST, 4'($urandom()), $urandom(), cx, cy, cz, rad);
    endtask

    function automatic logic signed [31:0] rnd_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 8 << FB)) - (4 <<< FB);
        endcase
    endfunction

    function automatic logic [30:0] rnd_radius();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 31'($urandom());
            default: return 31'($urandom_range(0, 2 << FB));
        endcase
    endfunction

    // spheres against the reset planes, field extremes included
    task automatic test_reset_planes();
        test_sphere('0, '0, ONE / 2, '0);
        test_sphere(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0);
        test_sphere(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF);
        test_sphere(2 * ONE, '0, '0, '0);
        test_sphere(2 * ONE, '0, '0, 31'(2 * ONE));
        test_sphere('0, -2 * ONE, '0, 31'(ONE / 2));
        test_sphere('0, '0, -ONE, '0);
        test_sphere('0, '0, ONE, '0);
        test_sphere(32'sh5555_5555, 32'shAAAA_AAAA, '0, 31'h2AAA_AAAA);
    endtask

    // directed matrices: scaled, zero w, alternating extremes
    task automatic test_special_matrices();
        logic signed [31:0] m[16];
        foreach (m[i]) m[i] = (i % 5 == 0) ? 2 * ONE : '0;
        load_matrix(m);
        test_sphere(ONE, ONE, ONE, '0);
        test_sphere(3 * ONE, '0, ONE, '0);
        foreach (m[i]) m[i] = '0;
        load_matrix(m);
        test_sphere('0, '0, '0, '0);
        test_sphere(ONE, -ONE, ONE, 31'(ONE));
        foreach (m[i]) m[i] = (i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        load_matrix(m);
        test_sphere(rnd_coord(), rnd_coord(), rnd_coord(), rnd_radius());
        send_item(vfc_pkg::OP_LOAD, 4'd3, -32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0, '0,
                  31'h7FFF_FFFF);
        send_item(vfc_pkg::OP_LOAD, vfc_pkg::LAST_ENTRY, ONE, '0, '0, '0, '0);
        test_sphere('0, '0, '0, '0);
    endtask

    // random perspective-like matrices, then mostly sphere tests
    task automatic test_random_frames(input int n_target);
        logic signed [31:0] m[16];
        while (n_items < n_target) begin
            foreach (m[i]) begin
                case ($urandom_range(0, 5))
                    0:       m[i] = $urandom();
                    1:       m[i] = '0;
                    default: m[i] = ((i % 5 == 0) ? ONE : 0)
                                    + $signed($urandom_range(0, ONE)) - ONE / 2;
                endcase
            end
            // sometimes a partial load without rebuild
            if ($urandom_range(0, 4) == 0)
                send_item(vfc_pkg::OP_LOAD, 4'($urandom_range(0, 14)), $urandom(),
                          $urandom(), $urandom(), $urandom(), 31'($urandom()));
            else
                load_matrix(m);
            repeat ($urandom_range(10, 40))
                test_sphere(rnd_coord(), rnd_coord(), rnd_coord(), rnd_radius());
        end
    endtask

    // long output stall while tests keep coming
    task automatic test_output_stall();
        hold_off = 1'b1;
        repeat (12) test_sphere(rnd_coord(), rnd_coord(), rnd_coord(), rnd_radius());
        go_idle();
        hold_off = 1'b0;
    endtask

    // receiver stall pattern plus the long hold-off
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_ready <= 1'b0;
                repeat (600) @(negedge i_clk);
                i_out_ready <= 1'b1;
                wait (!hold_off);
            end else begin
                i_out_ready <= ($urandom_range(0, 99) < 60) || (n_items % 300 < 40);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (inside_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result inside=%0b", o_inside_res);
            end else begin
                want = inside_q.pop_front();
                n_checked++;
                if (o_inside_res !== want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch test %0d: expected inside=%0b got %0b",
                                 n_checked, want, o_inside_res);
                end
            end
        end
    end

    // watchdog on cycles with no accepted item and no taken result
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("view_frustum_sphere_cull regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_operation = vfc_pkg::OP_LOAD;
        i_entry_index = '0;
        i_entry_value = '0;
        i_center_x = '0;
        i_center_y = '0;
        i_center_z = '0;
        i_radius = '0;
        hold_off = 1'b0;
        burst_mode = 1'b0;
        idle_cycles = 0;
        foreach (mat_entry[i]) mat_entry[i] = (i % 5 == 0) ? longint'(ONE) : 0;
        build_planes();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_planes();
        test_special_matrices();
        test_output_stall();
        test_random_frames(2000);
        test_output_stall();
        go_idle();

        while (inside_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        $display("covered %0d items: %0d loads, %0d plane rebuilds, %0d sphere tests",
                 n_items, n_loads, n_rebuilds, n_tests);
        $display("%0d spheres inside, %0d outside, %0d errors",
                 n_inside, n_tests - n_inside, n_errors);
        if (n_errors == 0)
            $display("view_frustum_sphere_cull regression: pass");
        else
            $display("view_frustum_sphere_cull regression: fail");
        $finish;
    end

endmodule
